FILE: src/dws_pkg.sv
package dws_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int OCC_W = 5;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;
  localparam logic [2:0] REQ_COUNT      = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic       take;
    logic       push;
    logic       pop;
    logic       pop_cap;
    logic       scan_init;
    logic       scan_step;
    logic       st_load;
    logic [1:0] st_code;
    logic       pos_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_search;
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

  // ring index a + b, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) s = s - (IDX_W+1)'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

FILE: src/dws_ram.sv
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/dws_datapath.sv
module dws_datapath import dws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [2:0]              in_req_type,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [POS_W-1:0]        out_found_position,
  output logic [OCC_W-1:0]        out_entry_count,
  output logic signed [VAL_W-1:0] out_removed_value
);

  logic [2:0]              req_r;
  logic signed [VAL_W-1:0] val_r;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic [CNT_W-1:0]        issue_r, issue_nxt;
  logic                    dvld_r, dvld_nxt;
  logic [IDX_W-1:0]        didx_r;
  logic [1:0]              st_r;
  logic [CNT_W-1:0]        pos_r;
  logic [VAL_W-1:0]        rem_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [OCC_W-1:0]        out_cnt_r;
  logic [VAL_W-1:0]        out_rem_r;

  logic                    wr_en, rd_en;
  logic [IDX_W-1:0]        wr_addr, rd_addr;
  logic [VAL_W-1:0]        rd_data;
  logic [IDX_W-1:0]        occ_m1, front_dec, front_inc;
  logic                    is_front;
  logic                    issuing;

  assign occ_m1    = IDX_W'(occ_r - CNT_W'(1));
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + IDX_W'(1);
  assign is_front  = (req_r == REQ_PUSH_FRONT) || (req_r == REQ_POP_FRONT);
  assign issuing   = cmd.scan_step && (issue_r < occ_r);

  always_comb begin
    wr_en   = cmd.push;
    wr_addr = is_front ? front_dec : ring_add(front_r, occ_r[IDX_W-1:0]);
    rd_en   = cmd.pop || issuing;
    if (cmd.pop) begin
      rd_addr = is_front ? front_r : ring_add(front_r, occ_m1);
    end else begin
      rd_addr = ring_add(front_r, issue_r[IDX_W-1:0]);
    end
  end

  dws_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    if (cmd.push) begin
      occ_nxt = occ_r + CNT_W'(1);
      if (is_front) front_nxt = front_dec;
    end else if (cmd.pop) begin
      occ_nxt = occ_r - CNT_W'(1);
      if (is_front) front_nxt = front_inc;
    end
  end

  // read issue runs ahead of the compare by the registered RAM read
  always_comb begin
    issue_nxt = issue_r;
    dvld_nxt  = dvld_r;
    if (cmd.scan_init) begin
      issue_nxt = '0;
      dvld_nxt  = 1'b0;
    end else if (cmd.scan_step) begin
      dvld_nxt = issuing;
      if (issuing) issue_nxt = issue_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      issue_r     <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      issue_r     <= issue_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
      pos_r <= '0;
      rem_r <= '0;
    end
    if (issuing) didx_r <= issue_r[IDX_W-1:0];
    if (cmd.st_load) st_r <= cmd.st_code;
    if (cmd.pos_load) pos_r <= CNT_W'(didx_r) + CNT_W'(1);
    if (cmd.pop_cap) rem_r <= rd_data;
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_pos_r    <= POS_W'(pos_r);
      out_cnt_r    <= OCC_W'(occ_r);
      out_rem_r    <= rem_r;
    end
  end

  always_comb begin
    sts.is_push   = (req_r == REQ_PUSH_FRONT) || (req_r == REQ_PUSH_BACK);
    sts.is_pop    = (req_r == REQ_POP_FRONT) || (req_r == REQ_POP_BACK);
    sts.is_search = (req_r == REQ_SEARCH);
    sts.full      = (occ_r == CNT_W'(DEPTH));
    sts.empty     = (occ_r == '0);
    sts.hit       = dvld_r && (rd_data == $unsigned(val_r));
    sts.last      = dvld_r && (didx_r == occ_m1);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_entry_count    = out_cnt_r;
  assign out_removed_value  = $signed(out_rem_r);

endmodule

FILE: src/dws_ctrl.sv
module dws_ctrl import dws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POPD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.st_load = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt   = S_FIN;
        if (sts.is_push) begin
          if (sts.full) cmd.st_code = ST_FULL;
          else cmd.push = 1'b1;
        end else if (sts.is_pop) begin
          if (sts.empty) begin
            cmd.st_code = ST_EMPTY;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = S_POPD;
          end
        end else if (sts.is_search) begin
          if (sts.empty) begin
            cmd.st_code = ST_EMPTY;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_POPD: begin
        cmd.pop_cap = 1'b1;
        state_nxt   = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.st_load  = 1'b1;
          cmd.st_code  = ST_OK;
          cmd.pos_load = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.last) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_MISSING;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: src/deque_with_search.sv
// Bounded double-ended queue of signed 32-bit values in a ring buffer of DEPTH
// entries, with push/pop at either end, a search for a value and a count
// request; every request beat gives exactly one result beat. One request is
// worked on at a time: push, count and rejected requests pass through the
// execute and finish states, a pop adds a capture state, and a search a scan
// state that compares held entries from the front, since the single read
// port of the entry store delivers one entry per cycle to the comparator. A
// finished result sits in the output register while the next request is taken.
module deque_with_search import dws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_req_type,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [POS_W-1:0]        out_found_position,
  output logic [OCC_W-1:0]        out_entry_count,
  output logic signed [VAL_W-1:0] out_removed_value
);

  cmd_t cmd;
  sts_t sts;

  dws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dws_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_req_type),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_removed_value  (out_removed_value)
  );

endmodule

FILE: src/dws_checker.sv
module dws_checker import dws_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              out_status,
  input logic [POS_W-1:0]        out_found_position,
  input logic [OCC_W-1:0]        out_entry_count,
  input logic signed [VAL_W-1:0] out_removed_value
);

  // one request in flight: an accepted beat blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  a_pos_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_found_position != '0) |-> out_status == ST_OK)
    else $error("found position with non-ok status");

  a_removed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_removed_value != '0) |-> out_status == ST_OK)
    else $error("removed value with non-ok status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_found_position) && $stable(out_entry_count)
      && $stable(out_removed_value))
    else $error("stalled result beat changed");

endmodule

bind deque_with_search dws_checker u_dws_checker (.*);

FILE: sim/deque_with_search_tb.sv
`timescale 1ns / 100ps

module deque_with_search_tb;
  import dws_pkg::*;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        pos;
    logic [OCC_W-1:0]        count;
    logic signed [VAL_W-1:0] removed;
  } deque_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [2:0]              in_req_type;
  logic signed [VAL_W-1:0] in_item_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic [POS_W-1:0]        out_found_position;
  logic [OCC_W-1:0]        out_entry_count;
  logic signed [VAL_W-1:0] out_removed_value;

  // shadow copy of the ring buffer
  logic signed [VAL_W-1:0] shadow_store [DEPTH];
  int                      shadow_front = 0;
  int                      shadow_count = 0;

  deque_result_t awaited_results [$];
  int            mismatches = 0;
  bit            idle_en = 1'b0;
  bit            hold_req = 1'b0;

  logic signed [VAL_W-1:0] value_pool [8] =
    '{32'sd0, -32'sd1, 32'sd1, 32'sd7, -32'sd7, 32'sd42, 32'sh7fffffff, 32'sh80000000};

  deque_with_search dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_removed_value  (out_removed_value)
  );

  always #5 clk = ~clk;

  function automatic deque_result_t predict_deque(input logic [2:0] req,
                                                  input logic signed [VAL_W-1:0] val);
    deque_result_t res;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (req == REQ_PUSH_FRONT) begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_store[shadow_front] = val;
          shadow_count++;
        end else begin
          shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
          shadow_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (req == REQ_POP_FRONT) begin
          res.removed = shadow_store[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end else begin
          res.removed = shadow_store[(shadow_front + shadow_count - 1) % DEPTH];
          shadow_count--;
        end
      end
      REQ_SEARCH: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_MISSING;
          // first match from the front wins
          for (int i = 0; i < shadow_count; i++) begin
            if (res.status == ST_MISSING &&
                shadow_store[(shadow_front + i) % DEPTH] == val) begin
              res.status = ST_OK;
              res.pos = POS_W'(i + 1);
            end
          end
        end
      end
      default: ;
    endcase
    res.count = OCC_W'(shadow_count);
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return value_pool[$urandom_range(0, 7)];
  endfunction

  // mostly look for something that is held, otherwise a likely miss
  function automatic logic signed [VAL_W-1:0] search_value();
    if (shadow_count > 0 && $urandom_range(0, 2) != 0)
      return shadow_store[(shadow_front + $urandom_range(0, shadow_count - 1)) % DEPTH];
    return pick_value();
  endfunction

  task automatic send_request(input logic [2:0] req, input logic signed [VAL_W-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(predict_deque(req, val));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d",
                 $time, out_status);
        mismatches++;
      end else begin
        deque_result_t want;
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("found_position", 32'(want.pos), 32'(out_found_position));
        check_field("entry_count", 32'(want.count), 32'(out_entry_count));
        check_field("removed_value", want.removed, out_removed_value);
      end
    end
  end

  // receiver: random stall bursts, free stretches, and a long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end
    end
  end

  task automatic test_empty_queue();
    send_request(REQ_COUNT, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_SEARCH, 32'sd0);
    send_request(REQ_UNUSED_LO, 32'sh5a5a5a5a);
    send_request(REQ_UNUSED_HI, -32'sd1);
    send_request(REQ_PUSH_FRONT, 32'sh80000000);
    send_request(REQ_PUSH_BACK, 32'sh7fffffff);
    send_request(REQ_SEARCH, 32'sh7fffffff);
    send_request(REQ_SEARCH, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    // popping the only entry leaves an empty queue
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_COUNT, 32'sd0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, 32'(i) - 32'sd8);
    send_request(REQ_SEARCH, 32'sd6);
    send_request(REQ_SEARCH, 32'sd7);
    send_request(REQ_PUSH_FRONT, 32'sd99);
    send_request(REQ_PUSH_BACK, 32'sd99);
    send_request(REQ_COUNT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_PUSH_BACK, 32'sd6);
    // duplicate value: the one nearer the front is reported
    send_request(REQ_SEARCH, 32'sd6);
  endtask

  task automatic test_random_traffic(input int n_items, input bit allow_idle);
    int               fill_bias;
    int               pick;
    logic [2:0]       req;
    logic signed [VAL_W-1:0] val;
    fill_bias = 50;
    for (int k = 0; k < n_items; k++) begin
      // drift between filling and draining so both ends get hit
      if (k % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: fill_bias = 15;
          1: fill_bias = 50;
          default: fill_bias = 85;
        endcase
        idle_en = allow_idle && ($urandom_range(0, 4) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) req = REQ_COUNT;
      else if (pick < 7) req = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      else if (pick < 25) req = REQ_SEARCH;
      else if ($urandom_range(0, 99) < fill_bias)
        req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else
        req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      val = (req == REQ_SEARCH) ? search_value() : pick_value();
      send_request(req, val);
    end
  endtask

  task automatic test_receiver_hold();
    idle_en = 1'b0;
    hold_req = 1'b1;
    test_random_traffic(40, 1'b0);
    wait_all_results();
  endtask

  task automatic test_sender_pause();
    test_random_traffic(30, 1'b1);
    wait_all_results();
    test_random_traffic(30, 1'b1);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_COUNT;
    in_item_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_full_queue();
    test_random_traffic(1050, 1'b1);
    test_receiver_hold();
    test_sender_pause();
    // last beats back to back with no idling on either side
    test_random_traffic(150, 1'b0);

    wait_all_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("deque_with_search_tb passed");
    end else begin
      $display("deque_with_search_tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("deque_with_search_tb failed");
    $finish;
  end

endmodule
